// ===== rtl/rwmf_pkg.sv =====
// shared types and constants of the rgb window median filter
package rwmf_pkg;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int ROW_W       = 13;
    localparam int Y_W         = 12;
    localparam int HEIGHT_CAP  = 4096;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = FH_W;
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;

    // red in the low byte, blue in the high byte
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    typedef struct packed {
        logic store;
        logic emit;
        logic interior;
        logic frame_end;
        logic bypass;
    } item_ctrl_t;

endpackage

// ===== rtl/rwmf_ram.sv =====
// generic simple dual-port ram, one write port and two registered read ports
module rwmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/rwmf_median.sv =====
// rank-based median of one color channel over the window taps
module rwmf_median #(
    parameter int TAPS = 9
) (
    input  logic [rwmf_pkg::CH_W-1:0] taps [TAPS],
    output logic [rwmf_pkg::CH_W-1:0] median
);

    import rwmf_pkg::*;

    localparam int MID = TAPS / 2;

    logic [TAPS-1:0] ahead [TAPS];

    // tap j ranks ahead of tap i when smaller, ties broken by position
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                ahead[i][j] = (taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i));
            end
        end
    end

    // ranks form a permutation, so exactly one tap sits at the middle
    always_comb
    begin
        median = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            if ($countones(ahead[i]) == MID)
            begin
                median = median | taps[i];
            end
        end
    end

endmodule

// ===== rtl/rgb_window_median_filter_core.sv =====
// top level of the rgb window median filter: counters, row banks, window, output register
//
// usage
//   s_* carries pixels in raster order; s_tuser low marks a pixel beat, high a drain
//   beat with no pixel. m_* returns the filtered frame, one pixel per beat, m_tlast on
//   the last pixel of the frame. cfg_* writes frame_width (index 0) and frame_height
//   (index 1); a new size takes effect on the first pixel of the next frame.
//   each channel of a pixel at least RADIUS away from every edge is replaced by the
//   median of its (2*RADIUS+1)^2 window; pixels near an edge pass unchanged.
//   output trails input by RADIUS rows plus RADIUS pixels; once the whole frame is in,
//   one drain beat per missing pixel pushes out the tail.
// timing
//   one beat per clock sustained while the output is not stalled; every beat does at most
//   one write and two reads on the row banks in its accept cycle, so the banks never hold it back.
//   a result passes the bank read (stage 1), the window update (stage 2) and then the
//   output register before it is valid.
// reset and stall
//   reset clears counters and pipeline, frame size returns to 640 x 480 (clamped to
//   MAX_WIDTH); the row banks are not cleared, only rows of the current frame are read.
//   while m_tready is low two internal stages keep filling, then s_tready drops.
module rgb_window_median_filter_core #(
    parameter int RADIUS    = 1,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rwmf_pkg::PIX_W-1:0]       s_tdata,   // red_in, green_in, blue_in
    input  logic                             s_tuser,   // mode
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rwmf_pkg::PIX_W-1:0]       m_tdata,   // red_out, green_out, blue_out
    output logic                             m_tlast,   // frame_end
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rwmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rwmf_pkg::*;

    localparam int SIDE   = 2 * RADIUS + 1;
    localparam int TAPS   = SIDE * SIDE;
    localparam int BANKS  = SIDE;
    localparam int BANK_W = $clog2(BANKS);
    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int SZW_W  = $clog2(MAX_WIDTH + 1);
    localparam int TOT_W  = $clog2(MAX_WIDTH * HEIGHT_CAP + 1);
    localparam int RST_ACT_W = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
    localparam int RST_LAG   = RADIUS * RST_ACT_W + RADIUS;

    // zero becomes one, oversize becomes the cap
    function automatic logic [SZW_W-1:0] clamp_w(input logic [FW_W-1:0] w);
        logic [SZW_W-1:0] r;
        if (w == '0)
            r = SZW_W'(1);
        else if (32'(w) > MAX_WIDTH)
            r = SZW_W'(MAX_WIDTH);
        else
            r = SZW_W'(w);
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_h(input logic [FH_W-1:0] h);
        logic [ROW_W-1:0] r;
        if (h == '0)
            r = ROW_W'(1);
        else if (32'(h) > HEIGHT_CAP)
            r = ROW_W'(HEIGHT_CAP);
        else
            r = ROW_W'(h);
        return r;
    endfunction

    function automatic logic [TOT_W-1:0] lag_of(input logic [SZW_W-1:0] w);
        return TOT_W'(RADIUS * w + RADIUS);
    endfunction

    // bank holding the row k rows above the row in bank b
    function automatic logic [BANK_W-1:0] bank_back(input logic [BANK_W-1:0] b, input int k);
        logic [BANK_W:0] t;
        t = {1'b0, b} + (BANK_W+1)'(BANKS) - (BANK_W+1)'(k);
        if (t >= (BANK_W+1)'(BANKS))
            t = t - (BANK_W+1)'(BANKS);
        return t[BANK_W-1:0];
    endfunction

    // configuration registers
    logic [FW_W-1:0]   cfg_width_reg;
    logic [FH_W-1:0]   cfg_height_reg;

    // frame size in use
    logic [SZW_W-1:0]  act_w_reg,  act_w_next;
    logic [ROW_W-1:0]  act_h_reg,  act_h_next;
    logic [TOT_W-1:0]  act_lag_reg, act_lag_next;

    // write position, emit position, and pixels taken but not yet emitted
    logic [X_W-1:0]    col_reg,   col_next;
    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [BANK_W-1:0] wbank_reg, wbank_next;
    logic [X_W-1:0]    ex_reg,    ex_next;
    logic [Y_W-1:0]    ey_reg,    ey_next;
    logic [BANK_W-1:0] ebank_reg, ebank_next;
    logic [TOT_W-1:0]  pend_reg,  pend_next;

    // front-end decode
    logic              accept;
    logic              is_pixel;
    logic              do_latch;
    logic [SZW_W-1:0]  cur_w;
    logic [ROW_W-1:0]  cur_h;
    logic [TOT_W-1:0]  cur_lag;
    logic              do_store;
    logic              col_last;
    logic [ROW_W-1:0]  row_after;
    logic [TOT_W-1:0]  pend_after;
    logic              do_emit;
    logic              ex_last;
    logic              ey_last;
    logic              frame_done;
    logic              is_interior;
    logic              is_bypass;
    pixel_t            in_pix;
    item_ctrl_t        in_ctrl;

    // pipeline
    logic              s1_valid_reg;
    item_ctrl_t        s1_ctrl_reg;
    pixel_t            s1_pix_reg;
    logic [BANK_W-1:0] s1_wbank_reg;
    logic [BANK_W-1:0] s1_ebank_reg;
    logic              s2_valid_reg;
    item_ctrl_t        s2_ctrl_reg;
    pixel_t            s2_center_reg;
    pixel_t            win_reg [SIDE][SIDE];
    logic              out_valid_reg;
    pixel_t            out_pix_reg;
    logic              out_last_reg;

    logic              s1_go;
    logic              s2_go;
    logic              s2_free;
    logic              s1_free;

    logic [PIX_W-1:0]  col_data [BANKS];
    logic [PIX_W-1:0]  ctr_data [BANKS];
    pixel_t            col_vec [SIDE];
    pixel_t            s1_center;

    logic [CH_W-1:0]   taps_r [TAPS];
    logic [CH_W-1:0]   taps_g [TAPS];
    logic [CH_W-1:0]   taps_b [TAPS];
    pixel_t            med_pix;
    pixel_t            result_pix;

    assign cfg_ready = 1'b1;
    assign in_pix    = pixel_t'(s_tdata);
    assign accept    = s_tvalid && s_tready;
    assign is_pixel  = (s_tuser == MODE_PIXEL);

    // ------------------------------------------------------------------
    // front end: what the accepted beat stores and which pixel it emits
    // ------------------------------------------------------------------
    always_comb
    begin
        do_latch   = is_pixel && (row_reg == '0) && (col_reg == '0);
        cur_w      = do_latch ? clamp_w(cfg_width_reg)         : act_w_reg;
        cur_h      = do_latch ? clamp_h(cfg_height_reg)        : act_h_reg;
        cur_lag    = do_latch ? lag_of(clamp_w(cfg_width_reg)) : act_lag_reg;

        // a pixel after the frame is complete is dropped and acts as a drain
        do_store   = is_pixel && (row_reg < cur_h);
        col_last   = (SZW_W'(col_reg) + SZW_W'(1)) == cur_w;
        row_after  = row_reg + ROW_W'(do_store && col_last);
        pend_after = pend_reg + TOT_W'(do_store);

        // emit once the window of the pending pixel is complete, or the frame is in
        do_emit    = (row_after >= cur_h) || (pend_after > cur_lag);

        ex_last    = (SZW_W'(ex_reg) + SZW_W'(1)) == cur_w;
        ey_last    = (ROW_W'(ey_reg) + ROW_W'(1)) == cur_h;
        frame_done = do_emit && ex_last && ey_last;

        is_interior = (32'(ey_reg) >= RADIUS) && ((32'(ey_reg) + RADIUS) < 32'(cur_h))
                   && (32'(ex_reg) >= RADIUS) && ((32'(ex_reg) + RADIUS) < 32'(cur_w));

        // emitting the very pixel written in this cycle
        is_bypass  = do_store && do_emit && (ex_reg == col_reg)
                  && (ROW_W'(ey_reg) == row_reg);

        in_ctrl.store     = do_store;
        in_ctrl.emit      = do_emit;
        in_ctrl.interior  = is_interior;
        in_ctrl.frame_end = frame_done;
        in_ctrl.bypass    = is_bypass;
    end

    always_comb
    begin
        act_w_next   = act_w_reg;
        act_h_next   = act_h_reg;
        act_lag_next = act_lag_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        wbank_next   = wbank_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        ebank_next   = ebank_reg;
        pend_next    = pend_reg;

        if (accept)
        begin
            if (do_latch)
            begin
                act_w_next   = cur_w;
                act_h_next   = cur_h;
                act_lag_next = cur_lag;
            end

            if (frame_done)
            begin
                col_next   = '0;
                row_next   = '0;
                wbank_next = '0;
                ex_next    = '0;
                ey_next    = '0;
                ebank_next = '0;
                pend_next  = '0;
            end
            else
            begin
                if (do_store)
                begin
                    row_next = row_after;
                    if (col_last)
                    begin
                        col_next   = '0;
                        wbank_next = (wbank_reg == BANK_W'(BANKS - 1)) ? '0
                                   : wbank_reg + BANK_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + X_W'(1);
                    end
                end

                if (do_emit)
                begin
                    pend_next = pend_after - TOT_W'(1);
                    if (ex_last)
                    begin
                        ex_next    = '0;
                        ey_next    = ey_reg + Y_W'(1);
                        ebank_next = (ebank_reg == BANK_W'(BANKS - 1)) ? '0
                                   : ebank_reg + BANK_W'(1);
                    end
                    else
                    begin
                        ex_next = ex_reg + X_W'(1);
                    end
                end
                else
                begin
                    pend_next = pend_after;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= FW_W'(RST_FRAME_WIDTH);
            cfg_height_reg <= FH_W'(RST_FRAME_HEIGHT);
            act_w_reg      <= SZW_W'(RST_ACT_W);
            act_h_reg      <= ROW_W'(RST_FRAME_HEIGHT);
            act_lag_reg    <= TOT_W'(RST_LAG);
            col_reg        <= '0;
            row_reg        <= '0;
            wbank_reg      <= '0;
            ex_reg         <= '0;
            ey_reg         <= '0;
            ebank_reg      <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height_reg <= cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            act_w_reg   <= act_w_next;
            act_h_reg   <= act_h_next;
            act_lag_reg <= act_lag_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            wbank_reg   <= wbank_next;
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            ebank_reg   <= ebank_next;
            pend_reg    <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // row banks: bank b holds rows with row mod SIDE == b
    // port a reads the column under the new pixel, port b the pixel to emit
    // ------------------------------------------------------------------
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        rwmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk       (clk),
            .wr_en     (accept && do_store && (wbank_reg == BANK_W'(b))),
            .wr_addr   (col_reg),
            .wr_data   (s_tdata),
            .rd_en     (accept),
            .rd_addr_a (col_reg),
            .rd_data_a (col_data[b]),
            .rd_addr_b (ex_reg),
            .rd_data_b (ctr_data[b])
        );
    end

    // ------------------------------------------------------------------
    // stage handshakes
    // ------------------------------------------------------------------
    assign s2_go    = s2_valid_reg && (!s2_ctrl_reg.emit || !out_valid_reg || m_tready);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign s_tready = s1_free;

    // stage 1: bank data arrives, build the new window column in row order
    always_comb
    begin
        for (int k = 0; k < SIDE; k++)
        begin
            if (k == 0)
                col_vec[k] = s1_pix_reg;
            else
                col_vec[k] = pixel_t'(col_data[bank_back(s1_wbank_reg, k)]);
        end
        s1_center = s1_ctrl_reg.bypass ? s1_pix_reg : pixel_t'(ctr_data[s1_ebank_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_ctrl_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            s2_ctrl_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
                s1_ctrl_reg  <= in_ctrl;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_go;
                s2_ctrl_reg  <= s1_ctrl_reg;
            end
            if (s2_go && s2_ctrl_reg.emit)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= s2_ctrl_reg.frame_end;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= in_pix;
            s1_wbank_reg <= wbank_reg;
            s1_ebank_reg <= ebank_reg;
        end
        if (s1_go)
        begin
            s2_center_reg <= s1_center;
            // the window only slides on stored pixels
            if (s1_ctrl_reg.store)
            begin
                for (int j = 0; j < SIDE - 1; j++)
                begin
                    win_reg[j] <= win_reg[j + 1];
                end
                win_reg[SIDE - 1] <= col_vec;
            end
        end
        if (s2_go && s2_ctrl_reg.emit)
        begin
            out_pix_reg <= result_pix;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: per-channel median of the window
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < SIDE; j++)
        begin
            for (int k = 0; k < SIDE; k++)
            begin
                taps_r[j * SIDE + k] = win_reg[j][k].red;
                taps_g[j * SIDE + k] = win_reg[j][k].green;
                taps_b[j * SIDE + k] = win_reg[j][k].blue;
            end
        end
    end

    rwmf_median #(.TAPS(TAPS)) u_med_red   (.taps(taps_r), .median(med_pix.red));
    rwmf_median #(.TAPS(TAPS)) u_med_green (.taps(taps_g), .median(med_pix.green));
    rwmf_median #(.TAPS(TAPS)) u_med_blue  (.taps(taps_b), .median(med_pix.blue));

    // edge pixels pass through
    assign result_pix = s2_ctrl_reg.interior ? med_pix : s2_center_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== test/rwmf_stream_checker.sv =====
// stream checker for the rgb window median filter: predicts each output pixel and compares
`timescale 1ns / 100ps

module rwmf_stream_checker #(
    parameter int RADIUS    = 1,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rwmf_pkg::PIX_W-1:0]      s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rwmf_pkg::PIX_W-1:0]      m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwmf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [31:0]                     fail_count,
    output logic [31:0]                     pending
);

    import rwmf_pkg::*;

    localparam int SIDE      = 2 * RADIUS + 1;
    localparam int TAPS      = SIDE * SIDE;
    localparam int RING_ROWS = 2 * RADIUS + 2;

    typedef struct packed {
        logic   last;
        pixel_t px;
    } out_pixel_t;

    pixel_t       line_ring [0:RING_ROWS*MAX_WIDTH-1];
    out_pixel_t   filtered_q [$];
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    int unsigned  act_w;
    int unsigned  act_h;
    int unsigned  col_n;
    int unsigned  row_n;
    int unsigned  out_n;
    int unsigned  errors;

    function automatic int unsigned ring_slot(int unsigned row, int unsigned col);
        return (row % RING_ROWS) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    // sorted-middle of one channel over the window centred on (y, x)
    function automatic logic [CH_W-1:0] window_median(int unsigned y, int unsigned x, int sh);
        logic [CH_W-1:0]  v [0:TAPS-1];
        logic [PIX_W-1:0] word;
        logic [CH_W-1:0]  c;
        int n;
        int j;
        n = 0;
        for (int dy = 0; dy < SIDE; dy++) begin
            for (int dx = 0; dx < SIDE; dx++) begin
                word = line_ring[ring_slot(y - RADIUS + dy, x - RADIUS + dx)];
                c = word[sh +: CH_W];
                j = n;
                while (j > 0 && v[j-1] > c) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = c;
                n++;
            end
        end
        return v[TAPS/2];
    endfunction

    task automatic latch_frame_size();
        act_w = (width_reg == '0) ? 1 : 32'(width_reg);
        if (act_w > MAX_WIDTH)
            act_w = MAX_WIDTH;
        act_h = (height_reg == '0) ? 1 : 32'(height_reg);
        if (act_h > HEIGHT_CAP)
            act_h = HEIGHT_CAP;
    endtask

    task automatic advance_frame(input mode_t md, input pixel_t px);
        int unsigned total;
        int unsigned in_idx;
        int unsigned lag;
        int unsigned y;
        int unsigned x;
        out_pixel_t  res;
        if (md == MODE_PIXEL) begin
            if (row_n == 0 && col_n == 0)
                latch_frame_size();
            // a pixel after the frame is fully in is dropped and acts as a drain
            if (row_n < act_h) begin
                line_ring[ring_slot(row_n, col_n)] = px;
                col_n++;
                if (col_n >= act_w) begin
                    col_n = 0;
                    row_n++;
                end
            end
        end
        total  = act_w * act_h;
        in_idx = row_n * act_w + col_n;
        lag    = RADIUS * act_w + RADIUS;
        if (out_n >= total)
            return;
        if (!(row_n >= act_h || in_idx > out_n + lag))
            return;
        y = out_n / act_w;
        x = out_n % act_w;
        res.px = line_ring[ring_slot(y, x)];
        if (y >= RADIUS && y + RADIUS < act_h && x >= RADIUS && x + RADIUS < act_w) begin
            res.px.red   = window_median(y, x, 0);
            res.px.green = window_median(y, x, CH_W);
            res.px.blue  = window_median(y, x, 2 * CH_W);
        end
        res.last = (out_n + 1 == total);
        filtered_q.push_back(res);
        out_n++;
        if (out_n == total) begin
            out_n = 0;
            row_n = 0;
            col_n = 0;
        end
    endtask

    task automatic compare_pixel();
        out_pixel_t want;
        pixel_t     got;
        got = pixel_t'(m_tdata);
        if (filtered_q.size() == 0) begin
            $error("m_tdata: beat %h with no pixel pending", m_tdata);
            errors++;
            return;
        end
        want = filtered_q.pop_front();
        if (got.red !== want.px.red) begin
            $error("red_out: expected %0d, got %0d", want.px.red, got.red);
            errors++;
        end
        if (got.green !== want.px.green) begin
            $error("green_out: expected %0d, got %0d", want.px.green, got.green);
            errors++;
        end
        if (got.blue !== want.px.blue) begin
            $error("blue_out: expected %0d, got %0d", want.px.blue, got.blue);
            errors++;
        end
        if (m_tlast !== want.last) begin
            $error("frame_end: expected %0d, got %0d", want.last, m_tlast);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  = FW_W'(RST_FRAME_WIDTH);
            height_reg = FH_W'(RST_FRAME_HEIGHT);
            latch_frame_size();
            col_n  = 0;
            row_n  = 0;
            out_n  = 0;
            errors = 0;
            filtered_q.delete();
            fail_count <= '0;
            pending    <= '0;
        end
        else begin
            // a register written at this edge is seen from the next beat on
            if (s_tvalid && s_tready)
                advance_frame(mode_t'(s_tuser), pixel_t'(s_tdata));
            if (cfg_valid && cfg_ready) begin
                if (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH)
                    width_reg = cfg_data[FW_W-1:0];
                else
                    height_reg = cfg_data[FH_W-1:0];
            end
            if (m_tvalid && m_tready)
                compare_pixel();
            fail_count <= errors;
            pending    <= filtered_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// testbench top of the rgb window median filter: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb;
    import rwmf_pkg::*;

    localparam int FILTER_RADIUS = 1;
    localparam int LINE_MAX      = 1024;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 80;
    localparam int WIDE_BEATS    = 1120;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic [31:0]           fail_count;
    logic [31:0]           pending;

    // idling odds in percent, changed per phase
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    // frame generator state: register copies and position in the current frame
    int unsigned cfg_w_raw = RST_FRAME_WIDTH;
    int unsigned cfg_h_raw = RST_FRAME_HEIGHT;
    int unsigned fr_total = 0;
    int unsigned fr_lag = 0;
    int unsigned px_sent = 0;
    int unsigned tail_left = 0;
    int unsigned beat_n = 0;

    always #5 clk = ~clk;

    rgb_window_median_filter_core #(
        .RADIUS    (FILTER_RADIUS),
        .MAX_WIDTH (LINE_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rwmf_stream_checker #(
        .RADIUS    (FILTER_RADIUS),
        .MAX_WIDTH (LINE_MAX)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver back-pressure, one draw per cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // one input beat; valid stays high into the next beat unless a gap is drawn
    task automatic send_beat(input mode_t md, input pixel_t px);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // channel values from a few levels make ties in the window common
    function automatic pixel_t rand_pixel();
        pixel_t p;
        if ($urandom_range(0, 1) == 0) begin
            p = pixel_t'(PIX_W'($urandom));
        end
        else begin
            p.red   = CH_W'($urandom_range(0, 3) * 85);
            p.green = CH_W'($urandom_range(0, 3) * 85);
            p.blue  = CH_W'($urandom_range(0, 3) * 85);
        end
        return p;
    endfunction

    // let every due pixel out, then wait for work still in the pipe
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // config write; valid is left high so back-to-back writes need no re-raise
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            cfg_w_raw = 32'(data[FW_W-1:0]);
        else
            cfg_h_raw = 32'(data);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
        end
        else begin
            write_reg(REG_FRAME_HEIGHT, h);
            write_reg(REG_FRAME_WIDTH, w);
        end
        cfg_valid <= 1'b0;
    endtask

    // next beat of a well-formed frame: pixels, then the drain tail, with noise mixed in
    task automatic next_item();
        int unsigned w;
        int unsigned h;
        if (px_sent < fr_total || px_sent == 0) begin
            // early drain: ignored by the block
            if ($urandom_range(0, 15) == 0) begin
                send_beat(MODE_DRAIN, rand_pixel());
                return;
            end
            if (px_sent == 0) begin
                w = (cfg_w_raw == 0) ? 1 : cfg_w_raw;
                h = (cfg_h_raw == 0) ? 1 : cfg_h_raw;
                if (w > LINE_MAX)
                    w = LINE_MAX;
                if (h > HEIGHT_CAP)
                    h = HEIGHT_CAP;
                fr_total = w * h;
                fr_lag   = FILTER_RADIUS * w + FILTER_RADIUS;
            end
            send_beat(MODE_PIXEL, rand_pixel());
            px_sent++;
            if (px_sent == fr_total) begin
                tail_left = (fr_lag < fr_total - 1) ? fr_lag : fr_total - 1;
                if (tail_left == 0)
                    px_sent = 0;
            end
        end
        else begin
            // tail: a surplus pixel pushes out like a drain
            if ($urandom_range(0, 5) == 0)
                send_beat(MODE_PIXEL, rand_pixel());
            else
                send_beat(MODE_DRAIN, rand_pixel());
            tail_left--;
            if (tail_left == 0)
                px_sent = 0;
        end
        beat_n++;
    endtask

    task automatic run_items(input int unsigned n);
        int unsigned stop_at;
        stop_at = beat_n + n;
        while (beat_n < stop_at)
            next_item();
    endtask

    task automatic finish_frame();
        while (px_sent != 0)
            next_item();
    endtask

    initial begin
        int unsigned gaps [0:3];
        int unsigned stalls [0:3];
        pixel_t      px;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        gaps   = '{0, 74, 0, 34};
        stalls = '{0, 0, 74, 34};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drain beats right after reset change nothing
        send_beat(MODE_DRAIN, pixel_t'(24'hFFFFFF));
        send_beat(MODE_DRAIN, pixel_t'(24'h000000));

        // 3x3 frame, one interior pixel; top width bits set but masked off
        set_size({2'b11, 11'd3}, 13'd3);
        for (int k = 0; k < 9; k++) begin
            px.red   = CH_W'(k * 32);
            px.green = k[0] ? 8'hFF : 8'h00;
            px.blue  = CH_W'(255 - k * 32);
            send_beat(MODE_PIXEL, px);
        end
        // tail with a surplus pixel among the drains
        send_beat(MODE_PIXEL, pixel_t'(24'h5A5A5A));
        send_beat(MODE_DRAIN, pixel_t'(24'hA5A5A5));
        send_beat(MODE_DRAIN, pixel_t'(24'h000000));
        send_beat(MODE_DRAIN, pixel_t'(24'hFFFFFF));

        // zero size is taken as one pixel, frame_end on it
        set_size(13'd0, 13'd0);
        send_beat(MODE_PIXEL, pixel_t'(24'hFFFFFF));

        // narrow frame passes through; size change mid-frame waits for the next frame
        set_size(13'd2, 13'd3);
        for (int k = 0; k < 3; k++)
            send_beat(MODE_PIXEL, pixel_t'(PIX_W'($urandom)));
        set_size(13'd3, 13'd3);
        for (int k = 0; k < 3; k++)
            send_beat(MODE_PIXEL, pixel_t'(PIX_W'($urandom)));
        for (int k = 0; k < 3; k++)
            send_beat(MODE_DRAIN, pixel_t'(PIX_W'($urandom)));

        // random phases; a write may land mid-frame and apply to the next one
        for (int ph = 0; ph < PHASES; ph++) begin
            gap_pct   = gaps[ph % 4];
            stall_pct = stalls[ph % 4];
            w_data = CFG_DATA_W'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 12));
            w_data[CFG_DATA_W-1:FW_W] = (CFG_DATA_W-FW_W)'($urandom_range(0, 3));
            h_data = CFG_DATA_W'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8));
            set_size(w_data, h_data);
            run_items(PHASE_BEATS);
        end

        // oversize width and height clamp to the row store and the height cap;
        // only the first rows go in, enough to see the clamped line length
        finish_frame();
        set_size(13'h1FFF, 13'h1FFF);
        run_items(WIDE_BEATS);

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rwmf_pkg.sv
rtl/rwmf_ram.sv
rtl/rwmf_median.sv
rtl/rgb_window_median_filter_core.sv
test/rwmf_stream_checker.sv
test/tb.sv
